[sv/mmdu_pkg.sv]
// Shared types and constants of the MIPS multiply/divide unit.
// Used by mmdu_iter and mips_multiply_divide_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mmdu_pkg;

	localparam int WORD_W = 32;
	localparam int STEP_W = 5;

	// action codes
	localparam logic [2:0] ACT_MULT  = 3'd0;
	localparam logic [2:0] ACT_MULTU = 3'd1;
	localparam logic [2:0] ACT_DIV   = 3'd2;
	localparam logic [2:0] ACT_DIVU  = 3'd3;
	localparam logic [2:0] ACT_MTHI  = 3'd4;
	localparam logic [2:0] ACT_MTLO  = 3'd5;
	localparam logic [2:0] ACT_MFHI  = 3'd6;
	localparam logic [2:0] ACT_MFLO  = 3'd7;

	typedef struct packed {
		logic [2:0]        action;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
	} mmdu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic [WORD_W-1:0] hi_after;
		logic [WORD_W-1:0] lo_after;
	} mmdu_rsp_t;

	// start request from the sequencer to the iterative unit
	typedef struct packed {
		logic start;
		logic is_div;
	} mmdu_ctrl_t;

endpackage

`default_nettype wire

[sv/mmdu_iter.sv]
// Iterative unsigned shift-add multiplier / restoring divider, one bit per cycle.
// Depends on mmdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmdu_iter import mmdu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mmdu_ctrl_t        ctrl,
	input  wire logic [WORD_W-1:0] mag_a,
	input  wire logic [WORD_W-1:0] mag_b,
	output logic                   busy,
	output logic [WORD_W-1:0]      upper,
	output logic [WORD_W-1:0]      lower
);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic              div_q;
	logic [WORD_W-1:0] den_q;
	logic [WORD_W-1:0] upper_q;
	logic [WORD_W-1:0] lower_q;

	// one shared adder/subtractor, two bits wider than a word
	logic [WORD_W+1:0] op_x;
	logic [WORD_W+1:0] op_y;
	logic [WORD_W+1:0] sum;
	logic              no_borrow;

	always_comb begin
		if (div_q) begin
			op_x = {1'b0, upper_q, lower_q[WORD_W-1]};
			op_y = {2'b00, den_q};
			sum  = op_x + ~op_y + {{(WORD_W+1){1'b0}}, 1'b1};
		end else begin
			op_x = {2'b00, upper_q};
			op_y = lower_q[0] ? {2'b00, den_q} : '0;
			sum  = op_x + op_y;
		end
		no_borrow = ~sum[WORD_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			div_q  <= ctrl.is_div;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			den_q   <= mag_b;
			upper_q <= '0;
			lower_q <= mag_a;
		end else if (busy_q) begin
			if (div_q) begin
				// keep the difference only when the trial subtract fits
				upper_q <= no_borrow ? sum[WORD_W-1:0] : op_x[WORD_W-1:0];
				lower_q <= {lower_q[WORD_W-2:0], no_borrow};
			end else begin
				upper_q <= sum[WORD_W:1];
				lower_q <= {sum[0], lower_q[WORD_W-1:1]};
			end
		end
	end

	assign busy  = busy_q;
	assign upper = upper_q;
	assign lower = lower_q;

endmodule

`default_nettype wire

[sv/mips_multiply_divide_unit.sv]
// Top level of the MIPS multiply/divide unit: handshakes, sign handling, HI/LO.
// Depends on mmdu_pkg and mmdu_iter.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-------------------------------
//   req     | in  | req_valid / req_stall     | mmdu_req_t (action, operands)
//   rsp     | out | rsp_valid / rsp_stall     | mmdu_rsp_t (read, hi, lo)
//
// Multiply and divide results pass through 32 adder steps in mmdu_iter, then the
// RUN state that sees the pass end and the FIX state that applies signs; moves
// and reads skip the iteration and go from accept straight to FIX.
// One item is in flight at a time; req_stall is high until its result is
// loaded into the output register. A stalled rsp holds the result in the
// FIX state. Reset clears HI, LO, rsp_valid and the sequencer and iteration state.
`timescale 1ns / 1ps
`default_nettype none

module mips_multiply_divide_unit import mmdu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire mmdu_req_t  req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output mmdu_rsp_t       rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIX  = 2'd2;

	logic [1:0]        state_q;
	logic [2:0]        act_q;
	logic [WORD_W-1:0] opa_q;
	logic              neg_n_q;     // numerator / multiplicand negative
	logic              neg_r_q;     // quotient / product negative
	logic [WORD_W-1:0] hi_q;
	logic [WORD_W-1:0] lo_q;
	logic              rsp_valid_q;
	mmdu_rsp_t         rsp_q;

	logic              accept;
	logic              is_signed;
	logic              neg_a;
	logic              neg_b;
	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;
	mmdu_ctrl_t        ctrl;
	logic              core_busy;
	logic [WORD_W-1:0] core_upper;
	logic [WORD_W-1:0] core_lower;

	logic [2*WORD_W-1:0] prod;
	logic [WORD_W-1:0]   hi_nx;
	logic [WORD_W-1:0]   lo_nx;
	logic [WORD_W-1:0]   read_nx;
	logic                load;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// take magnitudes of signed operands before the unsigned iteration
	always_comb begin
		is_signed = (req.action == ACT_MULT) || (req.action == ACT_DIV);
		neg_a     = is_signed && req.operand_a[WORD_W-1];
		neg_b     = is_signed && req.operand_b[WORD_W-1];
		mag_a     = neg_a ? (~req.operand_a + 1'b1) : req.operand_a;
		mag_b     = neg_b ? (~req.operand_b + 1'b1) : req.operand_b;
		ctrl.start  = accept && !req.action[2];
		ctrl.is_div = req.action[1];
	end

	mmdu_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.mag_a  (mag_a),
		.mag_b  (mag_b),
		.busy   (core_busy),
		.upper  (core_upper),
		.lower  (core_lower)
	);

	// apply signs and form the new HI/LO; divide by zero and the overflow
	// case fall out of the unsigned pass with these sign rules
	always_comb begin
		prod    = {core_upper, core_lower};
		hi_nx   = hi_q;
		lo_nx   = lo_q;
		read_nx = '0;
		unique case (act_q)
			ACT_MULT: begin
				if (neg_r_q) begin
					prod = ~prod + 1'b1;
				end
				hi_nx = prod[2*WORD_W-1:WORD_W];
				lo_nx = prod[WORD_W-1:0];
			end
			ACT_MULTU: begin
				hi_nx = core_upper;
				lo_nx = core_lower;
			end
			ACT_DIV: begin
				hi_nx = neg_n_q ? (~core_upper + 1'b1) : core_upper;
				lo_nx = neg_r_q ? (~core_lower + 1'b1) : core_lower;
			end
			ACT_DIVU: begin
				hi_nx = core_upper;
				lo_nx = core_lower;
			end
			ACT_MTHI: hi_nx = opa_q;
			ACT_MTLO: lo_nx = opa_q;
			ACT_MFHI: read_nx = hi_q;
			ACT_MFLO: read_nx = lo_q;
			default: ;
		endcase
	end

	// load the output register once it is empty or being drained
	assign load = (state_q == ST_FIX) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			hi_q        <= '0;
			lo_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= req.action[2] ? ST_FIX : ST_RUN;
					end
				end
				ST_RUN: begin
					if (!core_busy) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load) begin
				rsp_valid_q <= 1'b1;
				hi_q        <= hi_nx;
				lo_q        <= lo_nx;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the item's action, operand a and sign flags for the FIX state; load the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= req.action;
			opa_q   <= req.operand_a;
			neg_n_q <= neg_a;
			neg_r_q <= neg_a ^ neg_b;
		end
		if (load) begin
			rsp_q.read_value <= read_nx;
			rsp_q.hi_after   <= hi_nx;
			rsp_q.lo_after   <= lo_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted item did not leave idle");

	a_run_needs_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(core_busy) |-> $past(accept))
		else $error("iterative unit started without an accepted item");

	a_rsp_matches_regs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.hi_after == hi_q) && (rsp_q.lo_after == lo_q))
		else $error("pending result disagrees with HI/LO");

	a_fix_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && !core_busy |=> (state_q == ST_FIX))
		else $error("sequencer missed the end of the iteration");
`endif

endmodule

`default_nettype wire
